[hw/rtl/rfhex_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhex_pkg
// Shared types and constants for the RFID ASCII hex frame decoder.
// ----------------------------------------------------------------------------
package rfhex_pkg;

  localparam logic [7:0]  START_BYTE   = 8'h02;
  localparam logic [7:0]  END_BYTE     = 8'h03;
  localparam logic [3:0]  FRAME_LEN    = 4'd14;
  localparam logic [3:0]  LAST_POS     = 4'd13;
  localparam logic [3:0]  TAG_FIRST    = 4'd3;
  localparam logic [3:0]  TAG_LAST     = 4'd10;
  localparam logic [3:0]  DATA_LAST    = 4'd10;
  localparam logic [3:0]  CHK_POS      = 4'd12;
  localparam logic [23:0] TIME_MAX     = 24'hFFFFFF;
  localparam logic [23:0] RETAIN_RESET = 24'd1000;

  // Result cause codes
  localparam logic CAUSE_FRAME   = 1'b0;
  localparam logic CAUSE_TIMEOUT = 1'b1;

  // Input item kind codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_START,
    KIND_END,
    KIND_HEX,
    KIND_OTHER
  } item_kind_t;

  // Classified item passed from front to back
  typedef struct packed {
    item_kind_t  kind;
    logic [3:0]  nibble;
  } work_item_t;

endpackage

[hw/rtl/rfhex_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhex_in_if
// Input channel: a serial byte or a millisecond tick per beat.
// ----------------------------------------------------------------------------
interface rfhex_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

[hw/rtl/rfhex_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhex_out_if
// Output channel: one tag change per beat.
// ----------------------------------------------------------------------------
interface rfhex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] tag_value;
  logic        cause;

  modport source (output valid, output tag_value, output cause, input ready);
  modport sink   (input valid, input tag_value, input cause, output ready);
endinterface

[hw/rtl/rfid_ascii_hex_frame_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_decoder_unit
// Decodes 14-byte ASCII hex frames from an RFID reader into a held tag.
// ----------------------------------------------------------------------------
// One input beat is accepted every clock cycle while the queue has room,
// either a serial byte or a 1 ms tick. Each beat is classified on entry,
// held in a two-entry queue and then executed by the frame and timer logic,
// which registers the result for the output channel. A result is
// produced only when the current tag changes: cause 0 for a valid frame with
// a new tag, cause 1 when retention_ms elapses and a nonzero tag is cleared.
// A result held on a stalled output stops execution, and the queue keeps
// taking beats until its two entries are full. Write retention_ms only while
// no beat is queued or unreported.
// ----------------------------------------------------------------------------
module rfid_ascii_hex_frame_decoder_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [23:0]    cfg_wr_data,
  rfhex_in_if.sink       in_ch,
  rfhex_out_if.source    out_ch
);
  import rfhex_pkg::*;

  logic       push;
  work_item_t push_item;
  logic       queue_full;
  logic       pop;
  logic       queue_not_empty;
  work_item_t head;

  // Classify incoming beats
  rfhex_front u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .func       (in_ch.func),
    .rx_byte    (in_ch.rx_byte),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // Decouple front and back
  rfhex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  // Execute frames and timer
  rfhex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (queue_not_empty),
    .item        (head),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_tag     (out_ch.tag_value),
    .out_cause   (out_ch.cause)
  );

endmodule

[hw/rtl/rfhex_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhex_front
// Accepts input beats and classifies each into tick, start, end, hex digit
// or other character, with the decoded nibble for hex digits.
// ----------------------------------------------------------------------------
module rfhex_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [7:0]            rx_byte,
  output logic                  push,
  output rfhex_pkg::work_item_t push_item,
  input  logic                  queue_full
);
  import rfhex_pkg::*;

  // Accept whenever the queue has room
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the beat
  always_comb begin
    push_item.nibble = rx_byte[3:0];
    push_item.kind   = KIND_OTHER;
    if (func == FUNC_TICK) begin
      push_item.kind = KIND_TICK;
    end else if (rx_byte == START_BYTE) begin
      push_item.kind = KIND_START;
    end else if (rx_byte == END_BYTE) begin
      push_item.kind = KIND_END;
    end else if (rx_byte inside {[8'h30:8'h39]}) begin
      push_item.kind = KIND_HEX;
    end else if (rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      push_item.kind   = KIND_HEX;
      push_item.nibble = rx_byte[3:0] + 4'd9;
    end
  end

endmodule

[hw/rtl/rfhex_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhex_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rfhex_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rfhex_pkg::work_item_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output rfhex_pkg::work_item_t head
);
  import rfhex_pkg::*;

  work_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/rfhex_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhex_back
// Executes classified items: assembles the frame, checks start, hex and
// checksum, tracks the current tag and retention time, and registers results.
// ----------------------------------------------------------------------------
module rfhex_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [23:0]           cfg_wr_data,
  input  logic                  item_valid,
  input  rfhex_pkg::work_item_t item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_tag,
  output logic                  out_cause
);
  import rfhex_pkg::*;

  logic [23:0] retention_ms;
  logic [3:0]  byte_index;
  logic [31:0] current_tag;
  logic [23:0] elapsed_ms;
  logic        start_ok;
  logic        hex_ok;
  logic        chk_ok;
  logic [7:0]  pair;
  logic [7:0]  sum;
  logic [31:0] tag_acc;

  logic [3:0]  byte_index_next;
  logic [31:0] current_tag_next;
  logic [23:0] elapsed_ms_next;
  logic        start_ok_next;
  logic        hex_ok_next;
  logic        chk_ok_next;
  logic [7:0]  pair_next;
  logic [7:0]  sum_next;
  logic [31:0] tag_acc_next;
  logic        emit;
  logic [31:0] emit_tag;
  logic        emit_cause;

  logic [3:0]  pos;
  logic [3:0]  pos_inc;
  logic [7:0]  pair_shift;
  logic [23:0] elapsed_inc;

  // Take the next item when the output register is free or draining
  assign pop = item_valid && (!out_valid || out_ready);

  // Retention register
  always_ff @(posedge clk) begin
    if (rst) begin
      retention_ms <= RETAIN_RESET;
    end else if (cfg_wr_en) begin
      retention_ms <= cfg_wr_data;
    end
  end

  // Execute one item
  always_comb begin
    pos         = (item.kind == KIND_START) ? 4'd0 : byte_index;
    pos_inc     = pos + 4'd1;
    pair_shift  = {pair[3:0], item.nibble};
    elapsed_inc = (elapsed_ms == TIME_MAX) ? elapsed_ms : elapsed_ms + 24'd1;

    byte_index_next  = byte_index;
    current_tag_next = current_tag;
    elapsed_ms_next  = elapsed_ms;
    start_ok_next    = start_ok;
    hex_ok_next      = hex_ok;
    chk_ok_next      = chk_ok;
    pair_next        = pair;
    sum_next         = sum;
    tag_acc_next     = tag_acc;
    emit             = 1'b0;
    emit_tag         = current_tag;
    emit_cause       = CAUSE_FRAME;

    if (pop) begin
      if (item.kind == KIND_TICK) begin
        // Count time; clear the tag once retention is exceeded
        elapsed_ms_next = elapsed_inc;
        if (elapsed_inc > retention_ms) begin
          elapsed_ms_next  = 24'd0;
          current_tag_next = 32'd0;
          emit             = (current_tag != 32'd0);
          emit_tag         = 32'd0;
          emit_cause       = CAUSE_TIMEOUT;
        end
      end else if (pos != FRAME_LEN) begin
        // Store the byte into the running frame
        byte_index_next = pos_inc;
        if (pos == 4'd0) begin
          start_ok_next = (item.kind == KIND_START);
          hex_ok_next   = 1'b1;
          sum_next      = 8'd0;
        end else if (pos <= CHK_POS) begin
          hex_ok_next = hex_ok && (item.kind == KIND_HEX);
          pair_next   = pair_shift;
          if (!pos[0] && pos <= DATA_LAST) begin
            sum_next = sum ^ pair_shift;
          end
          if (pos == CHK_POS) begin
            chk_ok_next = (pair_shift == sum);
          end
          if (pos >= TAG_FIRST && pos <= TAG_LAST) begin
            tag_acc_next = {tag_acc[27:0], item.nibble};
          end
        end
        if (item.kind == KIND_END) begin
          if (pos != LAST_POS) begin
            // Drop a frame with a misplaced end byte
            byte_index_next = 4'd0;
          end else if (start_ok && hex_ok && chk_ok) begin
            current_tag_next = tag_acc;
            elapsed_ms_next  = 24'd0;
            emit             = (tag_acc != current_tag);
            emit_tag         = tag_acc;
            emit_cause       = CAUSE_FRAME;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= 4'd0;
      current_tag <= 32'd0;
      elapsed_ms  <= 24'd0;
      out_valid   <= 1'b0;
    end else begin
      byte_index  <= byte_index_next;
      current_tag <= current_tag_next;
      elapsed_ms  <= elapsed_ms_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame accumulators and result payload
  always_ff @(posedge clk) begin
    start_ok <= start_ok_next;
    hex_ok   <= hex_ok_next;
    chk_ok   <= chk_ok_next;
    pair     <= pair_next;
    sum      <= sum_next;
    tag_acc  <= tag_acc_next;
    if (emit) begin
      out_tag   <= emit_tag;
      out_cause <= emit_cause;
    end
  end

  // Write index never runs past the full frame
  assert property (@(posedge clk) disable iff (rst) byte_index <= FRAME_LEN)
    else $error("byte index beyond frame length");

  // A stalled result is never overwritten
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |-> !pop)
    else $error("item executed while result stalled");

  // Timeout results always report an empty tag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_cause == CAUSE_TIMEOUT) |-> out_tag == 32'd0)
    else $error("timeout result carries a tag");

  // A result always reflects the tag held afterwards
  assert property (@(posedge clk) disable iff (rst) emit |=> out_valid && out_tag == current_tag)
    else $error("result does not match current tag");

endmodule
